// ===== rtl/jav_pkg.sv =====
// package for the joint attractor velocity controller
// types, codes and widths shared by the interfaces, the register file, the divider and the core
// no dependencies
package jav_pkg;

    localparam int JOINTS_DEF = 16;

    localparam int CMD_W   = 2;
    localparam int JOINT_W = 4;
    localparam int POS_W   = 24;
    localparam int NORM_W  = 18;
    localparam int FRC_W   = 32;
    localparam int VEL_W   = 32;
    localparam int ZONE_W  = 2;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 20;

    localparam logic [CMD_W-1:0] CMD_LIMITS = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ATTR   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FORCE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd3;

    localparam logic [ZONE_W-1:0] ZONE_FREE = 2'd0;
    localparam logic [ZONE_W-1:0] ZONE_LOW  = 2'd1;
    localparam logic [ZONE_W-1:0] ZONE_HIGH = 2'd2;

    localparam logic [CFG_IW-1:0] CFG_PERIOD = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_WEIGHT = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_STIFF  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_DAMP   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_SFMAX  = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_LFMAX  = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_NOGO   = 3'd6;

    // divider: dividend and divisor widths
    localparam int DIV_NW = 64;
    localparam int DIV_DW = 52;

    typedef struct packed {
        logic [9:0]  period_ms;
        logic [15:0] error_weight;
        logic [15:0] spring_stiffness;
        logic [15:0] damping_gain;
        logic [19:0] spring_force_max;
        logic [19:0] limit_force_max;
        logic [15:0] nogo_band;
    } t_cfg;

    typedef struct packed {
        logic signed [POS_W-1:0] prev_pos;
        logic signed [POS_W-1:0] attr;
        logic signed [POS_W-1:0] lo_lim;
        logic signed [POS_W-1:0] hi_lim;
        logic signed [FRC_W-1:0] jforce;
    } t_rec;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== rtl/jav_if.sv =====
// channel interfaces of the joint attractor velocity controller
// item, result and register write channels; depends on jav_pkg
interface jav_in_if;
    import jav_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic [JOINT_W-1:0]         joint;
    logic signed [POS_W-1:0]    position;
    logic signed [POS_W-1:0]    high_limit;
    logic signed [NORM_W-1:0]   norm_target;
    logic signed [FRC_W-1:0]    force_req;
    logic signed [FRC_W-1:0]    extra_force;
    modport source (output valid, cmd, joint, position, high_limit, norm_target, force_req,
                    extra_force, input ready);
    modport sink (input valid, cmd, joint, position, high_limit, norm_target, force_req,
                  extra_force, output ready);
endinterface

interface jav_out_if;
    import jav_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [JOINT_W-1:0]         joint_res;
    logic signed [VEL_W-1:0]    velocity_command;
    logic [ZONE_W-1:0]          limit_zone;
    modport source (output valid, joint_res, velocity_command, limit_zone, input ready);
    modport sink (input valid, joint_res, velocity_command, limit_zone, output ready);
endinterface

interface jav_cfg_if;
    import jav_pkg::*;
    logic              valid;
    logic              ready;
    logic [CFG_IW-1:0] index;
    logic [CFG_DW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/jav_cfg.sv =====
// register file holding the shared gains and limits
// depends on jav_pkg and jav_cfg_if
module jav_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    jav_cfg_if.sink       i_cfg,
    output jav_pkg::t_cfg o_cfg
);
    import jav_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_ms        <= 10'd20;
            r_cfg.error_weight     <= 16'd256;
            r_cfg.spring_stiffness <= 16'd50;
            r_cfg.damping_gain     <= 16'd10;
            r_cfg.spring_force_max <= 20'd800;
            r_cfg.limit_force_max  <= 20'd1600;
            r_cfg.nogo_band        <= 16'd2560;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_PERIOD: r_cfg.period_ms        <= i_cfg.data[9:0];
                CFG_WEIGHT: r_cfg.error_weight     <= i_cfg.data[15:0];
                CFG_STIFF:  r_cfg.spring_stiffness <= i_cfg.data[15:0];
                CFG_DAMP:   r_cfg.damping_gain     <= i_cfg.data[15:0];
                CFG_SFMAX:  r_cfg.spring_force_max <= i_cfg.data;
                CFG_LFMAX:  r_cfg.limit_force_max  <= i_cfg.data;
                CFG_NOGO:   r_cfg.nogo_band        <= i_cfg.data[15:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/jav_div.sv =====
// shared restoring divider, one quotient bit per cycle, unsigned
// depends on jav_pkg
module jav_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  jav_pkg::t_div_req i_req,
    output jav_pkg::t_div_rsp o_rsp
);
    import jav_pkg::*;

    localparam int CW = $clog2(DIV_NW);

    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_dvs;
    logic [DIV_NW-1:0] r_quo;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_DW:0]   w_sh;
    logic [DIV_DW:0]   w_sub;
    logic              w_ge;

    assign w_sh  = {r_rem, r_quo[DIV_NW-1]};
    assign w_sub = w_sh - {1'b0, r_dvs};
    assign w_ge  = (w_sh >= {1'b0, r_dvs});

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NW-2:0], w_ge};
            r_rem <= w_ge ? w_sub[DIV_DW-1:0] : w_sh[DIV_DW-1:0];
        end
    end

endmodule

// ===== rtl/joint_attractor_velocity_controller.sv =====
// joint attractor velocity controller: per-joint state in one record memory, a sequencer
// and a shared 64-step divider; depends on jav_pkg, jav_if, jav_cfg and jav_div
// sequencing: limits and force are written in dispatch, an attractor in a further state; a sample
// runs velocity, spring and band divides (spring, band skippable), then 1/1000 scaling to the result
// throughput: one item at a time; a new item is taken once the previous one has finished
// reset: synchronous active low, clears valid bits, sequencer and result valid, loads default gains
module joint_attractor_velocity_controller #(
    parameter int JOINTS = jav_pkg::JOINTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jav_in_if.sink    i_item,
    jav_out_if.source o_res,
    jav_cfg_if.sink   i_cfg
);
    import jav_pkg::*;

    localparam int AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_ATTR = 4'd2;
    localparam logic [3:0] S_SMP2 = 4'd3;
    localparam logic [3:0] S_VDIV = 4'd4;
    localparam logic [3:0] S_SMP3 = 4'd5;
    localparam logic [3:0] S_SMP4 = 4'd6;
    localparam logic [3:0] S_FDIV = 4'd7;
    localparam logic [3:0] S_SMP5 = 4'd8;
    localparam logic [3:0] S_LDIV = 4'd9;
    localparam logic [3:0] S_SMP6 = 4'd10;
    localparam logic [3:0] S_SMP7 = 4'd11;
    localparam logic [3:0] S_SMP8 = 4'd12;
    localparam logic [3:0] S_ODIV = 4'd13;
    localparam logic [3:0] S_OUT  = 4'd14;
    localparam logic [3:0] S_OSAT = 4'd15;

    localparam logic signed [56:0] ACC_LIM = 57'sd1 <<< 52;

    // floor(v/1000) for v below 2^26 is (v * RECIP_1000) >> 36
    localparam logic [26:0] RECIP_1000 = 27'd68719477;

    t_cfg     w_cfg;
    t_div_req w_req;
    t_div_rsp w_rsp;

    jav_cfg u_cfg (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(i_cfg), .o_cfg(w_cfg));
    jav_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    logic [3:0] r_state, n_state;

    // latched item
    logic [CMD_W-1:0]         r_cmd;
    logic [JOINT_W-1:0]       r_joint;
    logic signed [POS_W-1:0]  r_pos;
    logic signed [POS_W-1:0]  r_hi_in;
    logic signed [NORM_W-1:0] r_norm;
    logic signed [FRC_W-1:0]  r_freq;
    logic signed [FRC_W-1:0]  r_extra;

    // record memory and valid bits
    t_rec              r_mem [JOINTS];
    t_rec              r_rd;
    logic              w_we;
    t_rec              w_wdata;
    logic [AW-1:0]     w_addr;
    logic [JOINTS-1:0] r_seen, r_attr_ok, r_force_ok;

    logic w_accept, w_in_range;

    // datapath registers
    logic signed [42:0] r_p1;
    logic signed [35:0] r_vnum;
    logic signed [41:0] r_p;
    logic [ZONE_W-1:0]  r_zone;
    logic [24:0]        r_dist;
    logic [33:0]        r_emag;
    logic               r_eneg;
    logic [44:0]        r_lp;
    logic signed [35:0] r_v;
    logic [49:0]        r_b;
    logic signed [52:0] r_dv;
    logic [39:0]        r_a2;
    logic signed [28:0] r_fx;
    logic signed [54:0] r_flim;
    logic signed [53:0] r_acc;
    logic signed [63:0] r_ap;
    logic signed [VEL_W-1:0] r_ctrl;

    // scaling by 1/1000, sixteen dividend bits per cycle
    logic [63:0] r_dx;
    logic [63:0] r_dq;
    logic [9:0]  r_drem;
    logic [1:0]  r_dcnt;

    // result register
    logic                    r_ovalid;
    logic [JOINT_W-1:0]      r_ojoint;
    logic signed [VEL_W-1:0] r_ovel;
    logic [ZONE_W-1:0]       r_ozone;

    // combinational helpers
    logic [9:0]              w_per;
    logic [15:0]             w_nb;
    logic signed [POS_W-1:0] w_attr, w_q0;
    logic signed [FRC_W-1:0] w_force;
    logic signed [24:0]      w_diff, w_aerr, w_span;
    logic [16:0]             w_norm;
    logic signed [25:0]      w_pos26, w_lonb, w_hinb, w_dlo, w_dhi;
    logic [ZONE_W-1:0]       w_zone;
    logic [24:0]             w_dist;
    logic signed [42:0]      w_t;
    logic signed [POS_W-1:0] w_new_attr;
    logic [41:0]             w_pabs;
    logic [35:0]             w_vabs;
    logic [27:0]             w_a;
    logic [DIV_DW-1:0]       w_d;
    logic [DIV_NW-1:0]       w_fdiv;
    logic [27:0]             w_f;
    logic signed [56:0]      w_sum, w_clamp;
    logic [63:0]             w_apabs;
    logic signed [54:0]      w_oq, w_ctrl;
    logic [25:0]             w_dv;
    logic [52:0]             w_dprod;
    logic [15:0]             w_dqc;
    logic [25:0]             w_drem;

    assign w_accept   = i_item.valid & i_item.ready;
    assign w_in_range = (int'(i_item.joint) < JOINTS);
    assign w_addr     = AW'(r_joint);

    assign i_item.ready           = (r_state == S_IDLE);
    assign o_res.valid            = r_ovalid;
    assign o_res.joint_res        = r_ojoint;
    assign o_res.velocity_command = r_ovel;
    assign o_res.limit_zone       = r_ozone;

    always_comb begin
        w_per   = (w_cfg.period_ms == 10'd0) ? 10'd1 : w_cfg.period_ms;
        w_nb    = (w_cfg.nogo_band == 16'd0) ? 16'd1 : w_cfg.nogo_band;
        w_attr  = r_attr_ok[w_addr] ? r_rd.attr : '0;
        w_force = r_force_ok[w_addr] ? r_rd.jforce : '0;
        w_q0    = r_seen[w_addr] ? r_rd.prev_pos : r_pos;
        w_diff  = {r_pos[23], r_pos} - {w_q0[23], w_q0};
        w_aerr  = {w_attr[23], w_attr} - {r_pos[23], r_pos};
        w_span  = {r_rd.hi_lim[23], r_rd.hi_lim} - {r_rd.lo_lim[23], r_rd.lo_lim};
        if (r_norm[NORM_W-1])
            w_norm = '0;
        else if (r_norm > 18'sd65536)
            w_norm = 17'd65536;
        else
            w_norm = r_norm[16:0];
        w_pos26 = {{2{r_pos[23]}}, r_pos};
        w_lonb  = {{2{r_rd.lo_lim[23]}}, r_rd.lo_lim} + $signed({10'b0, w_nb});
        w_hinb  = {{2{r_rd.hi_lim[23]}}, r_rd.hi_lim} - $signed({10'b0, w_nb});
        w_dlo   = w_lonb - w_pos26;
        w_dhi   = w_pos26 - w_hinb;
        // low band wins where both bands overlap
        if (w_pos26 < w_lonb) begin
            w_zone = ZONE_LOW;
            w_dist = w_dlo[24:0];
        end else if (w_pos26 > w_hinb) begin
            w_zone = ZONE_HIGH;
            w_dist = w_dhi[24:0];
        end else begin
            w_zone = ZONE_FREE;
            w_dist = '0;
        end
        // truncate toward zero on the fraction scale
        w_t        = r_p1[42] ? ((r_p1 + 43'sd65535) >>> 16) : (r_p1 >>> 16);
        w_new_attr = r_rd.lo_lim + w_t[23:0];
        w_pabs     = r_p[41] ? 42'(-r_p) : 42'(r_p);
        w_vabs     = r_vnum[35] ? 36'(-r_vnum) : 36'(r_vnum);
        w_a        = {w_cfg.spring_force_max, 8'b0};
        w_d        = DIV_DW'(w_a) + DIV_DW'(r_b);
        w_fdiv     = DIV_NW'({r_a2, 16'b0}) + DIV_NW'(w_d) - 64'd1;
        w_f        = w_a - w_rsp.quotient[27:0];
        w_sum      = 57'(r_fx) + 57'(r_flim) + 57'(r_extra) + 57'(w_force) - 57'(r_dv);
        if (w_sum > ACC_LIM)
            w_clamp = ACC_LIM;
        else if (w_sum < -ACC_LIM)
            w_clamp = -ACC_LIM;
        else
            w_clamp = w_sum;
        w_apabs = r_ap[63] ? 64'(-r_ap) : 64'(r_ap);
        // long division by 1000, remainder below 1000 so each step stays under 2^26
        w_dv    = {r_drem, r_dx[63:48]};
        w_dprod = 53'(w_dv) * 53'(RECIP_1000);
        w_dqc   = w_dprod[51:36];
        w_drem  = w_dv - (26'(w_dqc) * 26'd1000);
        w_oq    = r_ap[63] ? -$signed({1'b0, r_dq[53:0]})
                           : $signed({1'b0, r_dq[53:0]});
        w_ctrl  = 55'(r_v) + w_oq;
    end

    // memory write-back and divider requests
    always_comb begin
        w_we    = 1'b0;
        w_wdata = r_rd;
        w_req   = '0;
        case (r_state)
            S_DISP: begin
                case (r_cmd)
                    CMD_LIMITS: begin
                        w_we           = 1'b1;
                        w_wdata.lo_lim = r_pos;
                        w_wdata.hi_lim = r_hi_in;
                    end
                    CMD_FORCE: begin
                        w_we           = 1'b1;
                        w_wdata.jforce = r_freq;
                    end
                    CMD_SAMPLE: begin
                        w_we             = 1'b1;
                        w_wdata.prev_pos = r_pos;
                    end
                    default: begin
                    end
                endcase
            end
            S_ATTR: begin
                w_we         = 1'b1;
                w_wdata.attr = w_new_attr;
            end
            S_SMP2: begin
                w_req.start    = 1'b1;
                w_req.dividend = DIV_NW'(w_vabs);
                w_req.divisor  = DIV_DW'(w_per);
            end
            S_SMP4: begin
                if (w_cfg.spring_force_max != '0 && r_b != '0) begin
                    w_req.start    = 1'b1;
                    w_req.dividend = w_fdiv;
                    w_req.divisor  = w_d;
                end
            end
            S_SMP5: begin
                if (r_zone != ZONE_FREE) begin
                    w_req.start    = 1'b1;
                    w_req.dividend = DIV_NW'({r_lp, 8'b0});
                    w_req.divisor  = DIV_DW'(w_nb);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept && w_in_range) n_state = S_DISP;
            S_DISP: begin
                case (r_cmd)
                    CMD_ATTR:   n_state = S_ATTR;
                    CMD_SAMPLE: n_state = S_SMP2;
                    default:    n_state = S_IDLE;
                endcase
            end
            S_ATTR: n_state = S_IDLE;
            S_SMP2: n_state = S_VDIV;
            S_VDIV: if (w_rsp.done) n_state = S_SMP3;
            S_SMP3: n_state = S_SMP4;
            S_SMP4: n_state = w_req.start ? S_FDIV : S_SMP5;
            S_FDIV: if (w_rsp.done) n_state = S_SMP5;
            S_SMP5: n_state = w_req.start ? S_LDIV : S_SMP6;
            S_LDIV: if (w_rsp.done) n_state = S_SMP6;
            S_SMP6: n_state = S_SMP7;
            S_SMP7: n_state = S_SMP8;
            S_SMP8: n_state = S_ODIV;
            S_ODIV: if (r_dcnt == 2'd3) n_state = S_OSAT;
            S_OSAT: n_state = S_OUT;
            S_OUT:  if (!r_ovalid || o_res.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_in_range) r_rd <= r_mem[AW'(i_item.joint)];
        if (w_we) r_mem[w_addr] <= w_wdata;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_seen     <= '0;
            r_attr_ok  <= '0;
            r_force_ok <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DISP && r_cmd == CMD_SAMPLE) r_seen[w_addr] <= 1'b1;
            if (r_state == S_DISP && r_cmd == CMD_FORCE) r_force_ok[w_addr] <= 1'b1;
            if (r_state == S_ATTR) r_attr_ok[w_addr] <= 1'b1;
            if (r_state == S_OUT && (!r_ovalid || o_res.ready))
                r_ovalid <= 1'b1;
            else if (o_res.ready)
                r_ovalid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_item.cmd;
            r_joint <= i_item.joint;
            r_pos   <= i_item.position;
            r_hi_in <= i_item.high_limit;
            r_norm  <= i_item.norm_target;
            r_freq  <= i_item.force_req;
            r_extra <= i_item.extra_force;
        end
        case (r_state)
            S_DISP: begin
                r_p1   <= $signed({1'b0, w_norm}) * w_span;
                r_vnum <= 36'(w_diff) * 36'sd1000;
                r_p    <= $signed({1'b0, w_cfg.error_weight}) * w_aerr;
                r_zone <= w_zone;
                r_dist <= w_dist;
            end
            S_SMP2: begin
                r_emag <= w_pabs[41:8];
                r_eneg <= r_p[41];
                r_lp   <= w_cfg.limit_force_max * r_dist;
            end
            S_VDIV: begin
                if (w_rsp.done)
                    r_v <= r_vnum[35] ? -$signed({1'b0, w_rsp.quotient[34:0]})
                                      : $signed({1'b0, w_rsp.quotient[34:0]});
            end
            S_SMP3: begin
                r_b  <= w_cfg.spring_stiffness * r_emag;
                r_dv <= $signed({1'b0, w_cfg.damping_gain}) * r_v;
                r_a2 <= w_cfg.spring_force_max * w_cfg.spring_force_max;
            end
            S_SMP4: begin
                if (!w_req.start) r_fx <= '0;
            end
            S_FDIV: begin
                if (w_rsp.done)
                    r_fx <= r_eneg ? -$signed({1'b0, w_f}) : $signed({1'b0, w_f});
            end
            S_SMP5: begin
                if (!w_req.start) r_flim <= '0;
            end
            S_LDIV: begin
                if (w_rsp.done)
                    r_flim <= (r_zone == ZONE_LOW) ? $signed({1'b0, w_rsp.quotient[53:0]})
                                                   : -$signed({1'b0, w_rsp.quotient[53:0]});
            end
            S_SMP6: r_acc <= w_clamp[53:0];
            S_SMP7: r_ap <= r_acc * $signed({1'b0, w_per});
            S_SMP8: begin
                r_dx   <= w_apabs;
                r_dq   <= '0;
                r_drem <= '0;
                r_dcnt <= '0;
            end
            S_ODIV: begin
                r_dx   <= {r_dx[47:0], 16'b0};
                r_dq   <= {r_dq[47:0], w_dqc};
                r_drem <= w_drem[9:0];
                r_dcnt <= r_dcnt + 2'd1;
            end
            S_OSAT: begin
                if (w_ctrl > 55'sd2147483647)
                    r_ctrl <= 32'sh7FFFFFFF;
                else if (w_ctrl < -55'sd2147483648)
                    r_ctrl <= 32'sh80000000;
                else
                    r_ctrl <= w_ctrl[31:0];
            end
            S_OUT: begin
                if (!r_ovalid || o_res.ready) begin
                    r_ovel   <= r_ctrl;
                    r_ojoint <= r_joint;
                    r_ozone  <= r_zone;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/jav_checker.sv =====
// port-level checks for the joint attractor velocity controller, bound to the top level
// depends on jav_pkg
module jav_checker #(
    parameter int JOINTS = jav_pkg::JOINTS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic [jav_pkg::JOINT_W-1:0]  i_in_joint,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [jav_pkg::JOINT_W-1:0]  i_joint_res,
    input logic [jav_pkg::ZONE_W-1:0]   i_zone,
    input logic [jav_pkg::VEL_W-1:0]    i_vel
);
    import jav_pkg::*;

    // a waiting result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_vel)
            && $stable(i_joint_res) && $stable(i_zone))
        else $error("result beat changed while stalled");

    a_zone_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_zone == ZONE_FREE || i_zone == ZONE_LOW || i_zone == ZONE_HIGH))
        else $error("bad limit zone");

    a_joint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> int'(i_joint_res) < JOINTS)
        else $error("result for a joint out of range");

    // an in-range beat occupies the sequencer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && int'(i_in_joint) < JOINTS |=> !i_in_ready)
        else $error("item taken while busy");

endmodule

bind joint_attractor_velocity_controller jav_checker #(.JOINTS(JOINTS)) u_jav_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_joint  (i_item.joint),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_joint_res (o_res.joint_res),
    .i_zone      (o_res.limit_zone),
    .i_vel       (o_res.velocity_command)
);

// ===== test/jav_checker.sv =====
`timescale 1ns / 1ps
// checker for the joint attractor velocity controller: watches item, result and register channels,
// predicts each velocity command and compares it; depends on jav_pkg and jav_if
module jav_scoreboard (
    input  logic i_clk,
    input  logic i_rst_n,
    jav_in_if    i_item,
    jav_out_if   i_res,
    jav_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    import jav_pkg::*;

    typedef struct {
        logic [JOINT_W-1:0]      joint;
        logic signed [VEL_W-1:0] vel;
        logic [ZONE_W-1:0]       zone;
    } t_vel_cmd;

    localparam longint ACCEL_CLAMP = longint'(1) <<< 52;

    t_vel_cmd vel_cmd_queue[$];
    t_cfg     gains;
    longint   last_pos[JOINTS_DEF];
    longint   attr_pos[JOINTS_DEF];
    longint   low_pos[JOINTS_DEF];
    longint   high_pos[JOINTS_DEF];
    longint   ext_force[JOINTS_DEF];
    bit       sampled[JOINTS_DEF];

    // sigmoid spring A*B/(A+B), rounded as the hardware does
    function automatic longint spring_push(longint err);
        longint unsigned a_max;
        longint unsigned mag;
        longint unsigned b_lin;
        longint unsigned den;
        longint unsigned f;
        a_max = longint'(gains.spring_force_max) * 256;
        mag   = (err < 0) ? -err : err;
        b_lin = longint'(gains.spring_stiffness) * mag;
        if (a_max == 0 || b_lin == 0) begin
            return 0;
        end
        den = a_max + b_lin;
        f   = a_max - (a_max * a_max + den - 1) / den;
        return (err < 0) ? -longint'(f) : longint'(f);
    endfunction

    function automatic t_vel_cmd predict_velocity(int j, longint pos, longint extra);
        t_vel_cmd r;
        longint   q0;
        longint   per;
        longint   band;
        longint   lmax;
        longint   vel;
        longint   err;
        longint   flim;
        longint   acc;
        longint   ctrl;
        q0          = sampled[j] ? last_pos[j] : pos;
        last_pos[j] = pos;
        sampled[j]  = 1'b1;
        per  = (gains.period_ms == 0) ? 1 : longint'(gains.period_ms);
        band = (gains.nogo_band == 0) ? 1 : longint'(gains.nogo_band);
        lmax = longint'(gains.limit_force_max) * 256;
        vel  = 1000 * (pos - q0) / per;
        err  = longint'(gains.error_weight) * (attr_pos[j] - pos) / 256;
        r.zone = ZONE_FREE;
        flim   = 0;
        // low band wins where the two overlap
        if (pos < low_pos[j] + band) begin
            r.zone = ZONE_LOW;
            flim   = lmax * (low_pos[j] + band - pos) / band;
        end else if (pos > high_pos[j] - band) begin
            r.zone = ZONE_HIGH;
            flim   = -(lmax * (pos - (high_pos[j] - band)) / band);
        end
        acc = -longint'(gains.damping_gain) * vel + spring_push(err) + flim + extra + ext_force[j];
        if (acc > ACCEL_CLAMP) acc = ACCEL_CLAMP;
        if (acc < -ACCEL_CLAMP) acc = -ACCEL_CLAMP;
        ctrl = vel + acc * per / 1000;
        if (ctrl > 64'sd2147483647) ctrl = 64'sd2147483647;
        if (ctrl < -64'sd2147483648) ctrl = -64'sd2147483648;
        r.joint = j[JOINT_W-1:0];
        r.vel   = ctrl[31:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_vel_cmd exp_cmd;
        longint   norm;
        int       j;
        if (!i_rst_n) begin
            vel_cmd_queue.delete();
            gains <= '{period_ms: 10'd20, error_weight: 16'd256, spring_stiffness: 16'd50,
                       damping_gain: 16'd10, spring_force_max: 20'd800,
                       limit_force_max: 20'd1600, nogo_band: 16'd2560};
            for (int i = 0; i < JOINTS_DEF; i++) begin
                last_pos[i]  = 0;
                attr_pos[i]  = 0;
                low_pos[i]   = 0;
                high_pos[i]  = 0;
                ext_force[i] = 0;
                sampled[i]   = 1'b0;
            end
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (vel_cmd_queue.size() == 0) begin
                    $error("unexpected result beat for joint %0d", i_res.joint_res);
                    o_fail_count++;
                end else begin
                    exp_cmd = vel_cmd_queue.pop_front();
                    o_checked++;
                    if (i_res.joint_res !== exp_cmd.joint) begin
                        $error("joint_res: expected %0d, got %0d", exp_cmd.joint, i_res.joint_res);
                        o_fail_count++;
                    end
                    if (i_res.velocity_command !== exp_cmd.vel) begin
                        $error("velocity_command: expected %0d, got %0d",
                               exp_cmd.vel, i_res.velocity_command);
                        o_fail_count++;
                    end
                    if (i_res.limit_zone !== exp_cmd.zone) begin
                        $error("limit_zone: expected %0d, got %0d", exp_cmd.zone, i_res.limit_zone);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_PERIOD: gains.period_ms        <= i_cfg.data[9:0];
                    CFG_WEIGHT: gains.error_weight     <= i_cfg.data[15:0];
                    CFG_STIFF:  gains.spring_stiffness <= i_cfg.data[15:0];
                    CFG_DAMP:   gains.damping_gain     <= i_cfg.data[15:0];
                    CFG_SFMAX:  gains.spring_force_max <= i_cfg.data;
                    CFG_LFMAX:  gains.limit_force_max  <= i_cfg.data;
                    CFG_NOGO:   gains.nogo_band        <= i_cfg.data[15:0];
                    default: ;
                endcase
            end
            if (i_item.valid && i_item.ready) begin
                j = int'(i_item.joint);
                case (i_item.cmd)
                    CMD_LIMITS: begin
                        low_pos[j]  = longint'(i_item.position);
                        high_pos[j] = longint'(i_item.high_limit);
                    end
                    CMD_ATTR: begin
                        norm = longint'(i_item.norm_target);
                        if (norm < 0) norm = 0;
                        if (norm > 65536) norm = 65536;
                        attr_pos[j] = low_pos[j] + norm * (high_pos[j] - low_pos[j]) / 65536;
                    end
                    CMD_FORCE: ext_force[j] = longint'(i_item.force_req);
                    default: begin
                        vel_cmd_queue.push_back(predict_velocity(j, longint'(i_item.position),
                                                                 longint'(i_item.extra_force)));
                    end
                endcase
            end
        end
        o_pending = vel_cmd_queue.size();
    end

endmodule

// ===== test/tb_joint_attractor_velocity_controller.sv =====
`timescale 1ns / 1ps
// testbench top for the joint attractor velocity controller: clock, reset, stimulus and verdict
// depends on jav_pkg, jav_if, the controller and jav_scoreboard
module tb_joint_attractor_velocity_controller;
    import jav_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int SETTLE      = 320;
    localparam int PHASE_ITEMS = 150;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   checked;
    int   idle_cycles;
    int   burst_left;
    int   items_sent;
    int   stall_mode;
    int   stall_left;
    bit   loaded[JOINTS_DEF];
    longint low_tab[JOINTS_DEF];
    longint high_tab[JOINTS_DEF];

    jav_in_if  item_ch ();
    jav_out_if res_ch ();
    jav_cfg_if cfg_ch ();

    joint_attractor_velocity_controller u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (item_ch),
        .o_res  (res_ch),
        .i_cfg  (cfg_ch)
    );

    jav_scoreboard u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch),
        .i_res       (res_ch),
        .i_cfg       (cfg_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: always ready, random stalls or long stalls, mode changes now and then
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            0:       res_ch.ready <= 1'b1;
            1:       res_ch.ready <= 1'($urandom_range(0, 1));
            default: res_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_joint_attractor_velocity_controller NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic longint clip24(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    task automatic put_item(logic [CMD_W-1:0] cmd, int j, longint pos, longint hi,
                            longint norm, longint frc, longint extra);
        if (burst_left == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            // some bursts are long enough to run with no gaps at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 10);
        end
        item_ch.valid       <= 1'b1;
        item_ch.cmd         <= cmd;
        item_ch.joint       <= j[JOINT_W-1:0];
        item_ch.position    <= pos[POS_W-1:0];
        item_ch.high_limit  <= hi[POS_W-1:0];
        item_ch.norm_target <= norm[NORM_W-1:0];
        item_ch.force_req   <= frc[FRC_W-1:0];
        item_ch.extra_force <= extra[FRC_W-1:0];
        do @(posedge i_clk); while (!item_ch.ready);
        @(negedge i_clk);
        burst_left--;
        items_sent++;
        if (cmd == CMD_LIMITS) begin
            loaded[j]   = 1'b1;
            low_tab[j]  = longint'(pos[POS_W-1:0] ^ 24'h800000) - 64'sd8388608;
            high_tab[j] = longint'(hi[POS_W-1:0] ^ 24'h800000) - 64'sd8388608;
        end
    endtask

    // valid stays high across back-to-back writes; the caller drops it after the last one
    task automatic write_reg(logic [CFG_IW-1:0] idx, longint data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data[CFG_DW-1:0];
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic random_item();
        int     j;
        int     pick;
        longint lo;
        longint pos;
        longint extra;
        pick = $urandom_range(0, 99);
        j    = $urandom_range(0, JOINTS_DEF - 1);
        extra = ($urandom_range(0, 4) == 0) ? longint'(int'($urandom))
                                            : longint'($urandom_range(0, 131072)) - 65536;
        if (pick < 12 || !loaded[j]) begin
            if ($urandom_range(0, 3) == 0) begin
                put_item(CMD_LIMITS, j, longint'(int'($urandom)) >>> 8,
                         longint'(int'($urandom)) >>> 8, 0, 0, 0);
            end else begin
                lo = longint'($urandom_range(0, 2097152)) - 1048576;
                put_item(CMD_LIMITS, j, lo, clip24(lo + $urandom_range(0, 200000)), 0, 0, 0);
            end
        end else if (pick < 27) begin
            put_item(CMD_ATTR, j, 0, 0, longint'($urandom_range(0, 262143)) - 131072, 0, 0);
        end else if (pick < 35) begin
            put_item(CMD_FORCE, j, 0, 0, 0,
                     ($urandom_range(0, 3) == 0) ? longint'(int'($urandom))
                                                 : longint'($urandom_range(0, 200000)) - 100000,
                     0);
        end else begin
            case ($urandom_range(0, 4))
                0:       pos = longint'(int'($urandom)) >>> 8;
                1:       pos = low_tab[j] + $urandom_range(0, 6000) - 1000;
                2:       pos = high_tab[j] - $urandom_range(0, 6000) + 1000;
                default: pos = low_tab[j]
                               + $urandom_range(0, 1000) * (high_tab[j] - low_tab[j]) / 1000;
            endcase
            put_item(CMD_SAMPLE, j, clip24(pos), 0, 0, 0, extra);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        idle_cycles  = 0;
        burst_left   = 0;
        items_sent   = 0;
        stall_mode   = 0;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.cmd         = CMD_LIMITS;
        item_ch.joint       = '0;
        item_ch.position    = '0;
        item_ch.high_limit  = '0;
        item_ch.norm_target = '0;
        item_ch.force_req   = '0;
        item_ch.extra_force = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_PERIOD;
        cfg_ch.data  = '0;
        for (int i = 0; i < JOINTS_DEF; i++) loaded[i] = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part under reset gains
        put_item(CMD_LIMITS, 0, -64'sd8388608, 64'sd8388607, 0, 0, 0);
        put_item(CMD_LIMITS, 1, -2560, 2560, 0, 0, 0);
        put_item(CMD_LIMITS, 2, 5000, -5000, 0, 0, 0);
        put_item(CMD_LIMITS, 3, 0, 100000, 0, 0, 0);
        put_item(CMD_ATTR, 0, 0, 0, -131072, 0, 0);
        put_item(CMD_ATTR, 1, 0, 0, 131071, 0, 0);
        put_item(CMD_ATTR, 3, 0, 0, 32768, 0, 0);
        put_item(CMD_FORCE, 0, 0, 0, 0, -64'sd2147483648, 0);
        put_item(CMD_FORCE, 3, 0, 0, 0, 64'sd2147483647, 0);
        put_item(CMD_SAMPLE, 0, -64'sd8388608, 0, 0, 0, 64'sd2147483647);
        put_item(CMD_SAMPLE, 0, 64'sd8388607, 0, 0, 0, -64'sd2147483648);
        put_item(CMD_SAMPLE, 1, 0, 0, 0, 0, 0);
        put_item(CMD_SAMPLE, 3, 50000, 0, 0, 0, 0);
        put_item(CMD_SAMPLE, 3, 99000, 0, 0, 0, 0);
        put_item(CMD_SAMPLE, 2, 0, 0, 0, 0, 0);
        put_item(CMD_SAMPLE, 3, 50000, 0, 0, 0, -1);
        put_item(CMD_SAMPLE, 3, 1000, 0, 0, 0, 0);

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: begin
                    // largest gains
                    write_reg(CFG_PERIOD, 1023);
                    write_reg(CFG_WEIGHT, 65535);
                    write_reg(CFG_STIFF, 65535);
                    write_reg(CFG_DAMP, 65535);
                    write_reg(CFG_SFMAX, 1048575);
                    write_reg(CFG_LFMAX, 1048575);
                    write_reg(CFG_NOGO, 65535);
                end
                1: begin
                    // zero period and zero band fall back to one
                    write_reg(CFG_PERIOD, 0);
                    write_reg(CFG_WEIGHT, 0);
                    write_reg(CFG_STIFF, 0);
                    write_reg(CFG_DAMP, 0);
                    write_reg(CFG_SFMAX, 0);
                    write_reg(CFG_LFMAX, 0);
                    write_reg(CFG_NOGO, 0);
                end
                2: begin
                    write_reg(CFG_PERIOD, 1);
                    write_reg(CFG_WEIGHT, 256);
                    write_reg(CFG_STIFF, 1);
                    write_reg(CFG_DAMP, 1);
                    write_reg(CFG_SFMAX, 1);
                    write_reg(CFG_LFMAX, 1000000);
                    write_reg(CFG_NOGO, 1);
                end
                default: begin
                    write_reg(CFG_PERIOD, $urandom_range(1, 1000));
                    write_reg(CFG_WEIGHT, $urandom_range(0, 65535));
                    write_reg(CFG_STIFF, $urandom_range(1, 65535));
                    write_reg(CFG_DAMP, $urandom_range(0, 200));
                    write_reg(CFG_SFMAX, $urandom_range(1, 1000000));
                    write_reg(CFG_LFMAX, $urandom_range(0, 1000000));
                    write_reg(CFG_NOGO, $urandom_range(1, 65535));
                end
            endcase
            cfg_ch.valid <= 1'b0;
            repeat (PHASE_ITEMS) random_item();
        end

        drain();
        $display("run covered %0d items over four gain settings, %0d velocity commands checked",
                 items_sent, checked);
        if (fail_count == 0) begin
            $display("tb_joint_attractor_velocity_controller OK");
        end else begin
            $display("tb_joint_attractor_velocity_controller NOT OK");
        end
        $finish;
    end

endmodule
